// ===== hw/rtl/rxalu_pkg.sv =====
package rxalu_pkg;

  localparam int DATA_W     = 32;
  localparam int DIV_STAGES = DATA_W;

  localparam logic [5:0] OP_SPECIAL  = 6'h00;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1c;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1a;
  localparam logic [5:0] FN_DIVU  = 6'h1b;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2a;
  localparam logic [5:0] FN_SLTU  = 6'h2b;
  localparam logic [5:0] FN2_MUL  = 6'h02;

  localparam logic [1:0] KIND_JUMP = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_HILO = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  typedef enum logic [1:0] {
    CLS_ALU,
    CLS_MULT,
    CLS_MUL32,
    CLS_DIV
  } cls_t;

  typedef struct packed {
    cls_t                  cls;
    logic [1:0]            kind;
    logic [DATA_W-1:0]     res;
    logic [DATA_W-1:0]     hi;
    logic [DATA_W-1:0]     lo;
    logic [DATA_W-1:0]     dividend;
    logic                  neg_q;
    logic                  neg_r;
    logic                  div_zero;
    logic [2*DATA_W-1:0]   prod;
  } payload_t;

endpackage

// ===== hw/rtl/rxalu_div_pipe.sv =====
module rxalu_div_pipe
  import rxalu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [DATA_W-1:0] quotient,
  output logic [DATA_W-1:0] remainder
);

  // One quotient bit per stage, restoring division on magnitudes.
  logic [DATA_W-1:0] rem_r [DIV_STAGES];
  logic [DATA_W-1:0] quo_r [DIV_STAGES];
  logic [DATA_W-1:0] dvs_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] quo_in;
    logic [DATA_W-1:0] dvs_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign quo_in = quo_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end

    assign trial = {rem_in, quo_in[DATA_W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        quo_r[i] <= {quo_in[DATA_W-2:0], take};
        dvs_r[i] <= dvs_in;
      end
    end
  end

  assign quotient  = quo_r[DIV_STAGES-1];
  assign remainder = rem_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/rtype_execute_alu.sv =====
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_ready    | opcode, funct, shift_amount, operands, hi/lo
// out_     | output    | out_valid / out_ready  | rd_value, hi_out, lo_out, result_kind
//
// Every instruction passes one decode stage, 32 stages of the bit-per-stage divider and
// one result stage from transfer in to result valid. One instruction is accepted every
// cycle unless the pipeline holds. The whole pipeline advances together; it holds while the
// output register has a result that is not taken, and in_ready drops at that time.
// Reset (synchronous, active low) clears only the valid bits.
module rtype_execute_alu
  import rxalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [5:0]        in_opcode,
  input  logic [5:0]        in_funct,
  input  logic [4:0]        in_shift_amount,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  input  logic [DATA_W-1:0] in_hi_in,
  input  logic [DATA_W-1:0] in_lo_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_rd_value,
  output logic [DATA_W-1:0] out_hi_out,
  output logic [DATA_W-1:0] out_lo_out,
  output logic [1:0]        out_result_kind
);

  logic en;

  // The pipeline moves whenever the output register is free or being emptied.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Decode stage: the simple operations finish here, and the operands of multiply
  // and divide are turned into magnitudes with their signs kept aside.
  payload_t          dec_pl;
  logic              sgn_op;
  logic              sa;
  logic              sb;
  logic [DATA_W-1:0] ua_nxt;
  logic [DATA_W-1:0] ub_nxt;

  always_comb begin
    dec_pl          = '0;
    dec_pl.cls      = CLS_ALU;
    dec_pl.kind     = KIND_BAD;
    dec_pl.hi       = in_hi_in;
    dec_pl.lo       = in_lo_in;
    dec_pl.dividend = in_operand_a;
    sgn_op          = 1'b0;
    if (in_opcode == OP_SPECIAL) begin
      dec_pl.kind = KIND_REG;
      case (in_funct)
        FN_ADD, FN_ADDU: dec_pl.res = in_operand_a + in_operand_b;
        FN_SUB, FN_SUBU: dec_pl.res = in_operand_a - in_operand_b;
        FN_AND:          dec_pl.res = in_operand_a & in_operand_b;
        FN_OR:           dec_pl.res = in_operand_a | in_operand_b;
        FN_NOR:          dec_pl.res = ~(in_operand_a | in_operand_b);
        FN_SLT: begin
          dec_pl.res = {{(DATA_W-1){1'b0}},
                        ($signed(in_operand_a) < $signed(in_operand_b))};
        end
        FN_SLTU: begin
          dec_pl.res = {{(DATA_W-1){1'b0}}, (in_operand_a < in_operand_b)};
        end
        FN_SLL: dec_pl.res = in_operand_b << in_shift_amount;
        FN_SRL: dec_pl.res = in_operand_b >> in_shift_amount;
        FN_JR: begin
          dec_pl.res  = in_operand_a;
          dec_pl.kind = KIND_JUMP;
        end
        FN_MFHI: dec_pl.res = in_hi_in;
        FN_MFLO: dec_pl.res = in_lo_in;
        FN_MULT: begin
          dec_pl.cls  = CLS_MULT;
          dec_pl.kind = KIND_HILO;
          sgn_op      = 1'b1;
        end
        FN_MULTU: begin
          dec_pl.cls  = CLS_MULT;
          dec_pl.kind = KIND_HILO;
        end
        FN_DIV: begin
          dec_pl.cls  = CLS_DIV;
          dec_pl.kind = KIND_HILO;
          sgn_op      = 1'b1;
        end
        FN_DIVU: begin
          dec_pl.cls  = CLS_DIV;
          dec_pl.kind = KIND_HILO;
        end
        default: dec_pl.kind = KIND_BAD;
      endcase
    end else if (in_opcode == OP_SPECIAL2 && in_funct == FN2_MUL) begin
      dec_pl.cls  = CLS_MUL32;
      dec_pl.kind = KIND_REG;
    end
    sa              = sgn_op && in_operand_a[DATA_W-1];
    sb              = sgn_op && in_operand_b[DATA_W-1];
    ua_nxt          = sa ? (DATA_W'(0) - in_operand_a) : in_operand_a;
    ub_nxt          = sb ? (DATA_W'(0) - in_operand_b) : in_operand_b;
    // For a product, neg_q marks a negative product.
    dec_pl.neg_q    = sa ^ sb;
    dec_pl.neg_r    = sa;
    dec_pl.div_zero = (in_operand_b == '0);
  end

  logic              s0_vld_r;
  payload_t          s0_pl_r;
  logic [DATA_W-1:0] s0_ua_r;
  logic [DATA_W-1:0] s0_ub_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pl_r <= dec_pl;
      s0_ua_r <= ua_nxt;
      s0_ub_r <= ub_nxt;
    end
  end

  // Divider on the magnitudes; its output lines up with the last payload stage.
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;

  rxalu_div_pipe u_div (
    .clk      (clk),
    .en       (en),
    .dividend (s0_ua_r),
    .divisor  (s0_ub_r),
    .quotient (quo),
    .remainder(rem)
  );

  // The unsigned product of the magnitudes is registered next to the first
  // payload stage, and its sign is applied on the way into the second.
  logic [2*DATA_W-1:0] mul_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= {{DATA_W{1'b0}}, s0_ua_r} * {{DATA_W{1'b0}}, s0_ub_r};
    end
  end

  logic     pl_vld_r [DIV_STAGES];
  payload_t pl_r     [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_pl
    payload_t pl_nxt;
    logic     vld_nxt;

    if (i == 0) begin : g_first
      assign pl_nxt  = s0_pl_r;
      assign vld_nxt = s0_vld_r;
    end else if (i == 1) begin : g_sign
      always_comb begin
        pl_nxt      = pl_r[0];
        pl_nxt.prod = pl_r[0].neg_q ? ((2*DATA_W)'(0) - mul_r) : mul_r;
      end
      assign vld_nxt = pl_vld_r[0];
    end else begin : g_next
      assign pl_nxt  = pl_r[i-1];
      assign vld_nxt = pl_vld_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pl_vld_r[i] <= 1'b0;
      end else if (en) begin
        pl_vld_r[i] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r[i] <= pl_nxt;
      end
    end
  end

  // Result stage: pick the unit that did the work and fix the quotient and
  // remainder signs. Division by zero gives all ones and the dividend.
  payload_t          last;
  logic [DATA_W-1:0] res_nxt;
  logic [DATA_W-1:0] hi_nxt;
  logic [DATA_W-1:0] lo_nxt;

  assign last = pl_r[DIV_STAGES-1];

  always_comb begin
    res_nxt = last.res;
    hi_nxt  = last.hi;
    lo_nxt  = last.lo;
    case (last.cls)
      CLS_MULT: begin
        hi_nxt = last.prod[2*DATA_W-1:DATA_W];
        lo_nxt = last.prod[DATA_W-1:0];
      end
      CLS_MUL32: res_nxt = last.prod[DATA_W-1:0];
      CLS_DIV: begin
        if (last.div_zero) begin
          lo_nxt = '1;
          hi_nxt = last.dividend;
        end else begin
          lo_nxt = last.neg_q ? (DATA_W'(0) - quo) : quo;
          hi_nxt = last.neg_r ? (DATA_W'(0) - rem) : rem;
        end
      end
      default: res_nxt = last.res;
    endcase
    if (last.kind == KIND_HILO || last.kind == KIND_BAD) begin
      res_nxt = '0;
    end
  end

  logic              out_valid_r;
  logic [DATA_W-1:0] out_res_r;
  logic [DATA_W-1:0] out_hi_r;
  logic [DATA_W-1:0] out_lo_r;
  logic [1:0]        out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pl_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r  <= res_nxt;
      out_hi_r   <= hi_nxt;
      out_lo_r   <= lo_nxt;
      out_kind_r <= last.kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rd_value    = out_res_r;
  assign out_hi_out      = out_hi_r;
  assign out_lo_out      = out_lo_r;
  assign out_result_kind = out_kind_r;

endmodule
